@@ rtl/core/mau_pkg.sv @@
// package of widths and operation codes for the modular arithmetic unit
`default_nettype none

package mau_pkg;

    // field widths
    localparam int OPD_W  = 64;
    localparam int MOD_W  = 63;
    localparam int KIND_W = 2;

    // bit counter for the reduction pass, one operand bit per cycle
    localparam int CNT_W = $clog2(OPD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPD_W - 1);

    // operation codes
    localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SUB = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MUL = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RED = 2'd3;

    typedef logic [MOD_W-1:0] t_res;

endpackage

`default_nettype wire

@@ rtl/core/mau_if.sv @@
// valid/ready channel interfaces for operand items and results
`default_nettype none

interface mau_in_if;
    import mau_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [OPD_W-1:0]  operand_a;
    logic [OPD_W-1:0]  operand_b;

    modport source (output valid, output kind, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input kind, input operand_a, input operand_b,
                    output ready);
endinterface

interface mau_out_if;
    import mau_pkg::*;

    logic             valid;
    logic             ready;
    logic [MOD_W-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

@@ rtl/core/modular_arithmetic_unit_core.sv @@
// modular arithmetic unit: bit-serial reduction and interleaved modular multiply
// steps: accept, reduction (one operand bit per cycle, both operands in parallel),
//   sign fix and operation, for multiply one step per bit of the second operand up
//   to its top set bit and one more to see it shifted to zero, then the output register
// one item at a time: a new item is taken only once the last result is in the output register
// reset (synchronous, active low) sets the modulus to 1 and empties the output register
`default_nettype none

module modular_arithmetic_unit_core (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire [mau_pkg::MOD_W-1:0]   i_cfg_data,
    mau_in_if.sink                     i_item,
    mau_out_if.source                  o_res
);
    import mau_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RED  = 5'b00010,
        S_FIX  = 5'b00100,
        S_MUL  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [MOD_W-1:0]  r_mod;
    logic [KIND_W-1:0] r_kind;
    logic              r_neg_a, r_neg_b;
    logic [OPD_W-1:0]  r_mag_a, r_mag_b;
    logic [MOD_W-1:0]  r_a, r_b, r_acc;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_valid;
    logic [MOD_W-1:0]  r_out_result;

    logic [MOD_W-1:0]  w_mod;
    logic [OPD_W-1:0]  w_mod_x;
    logic [OPD_W-1:0]  w_ta, w_tb, w_da, w_db;
    logic [OPD_W-1:0]  w_in_mag_a, w_in_mag_b;
    logic [MOD_W-1:0]  w_fix_a, w_fix_b, w_op_res;
    logic              w_accept, w_out_free;

    // modular add with no overflow: compare against m minus the addend
    function automatic logic [MOD_W-1:0] mod_add(input logic [MOD_W-1:0] a,
                                                 input logic [MOD_W-1:0] b,
                                                 input logic [MOD_W-1:0] m);
        logic [MOD_W-1:0] gap;
        gap = m - b;
        if (a >= gap) begin
            mod_add = a - gap;
        end else begin
            mod_add = a + b;
        end
    endfunction

    // a zero modulus acts as one
    assign w_mod   = (r_mod == '0) ? MOD_W'(1) : r_mod;
    assign w_mod_x = {1'b0, w_mod};

    // magnitudes of the signed operands
    assign w_in_mag_a = i_item.operand_a[OPD_W-1] ? (~i_item.operand_a + OPD_W'(1))
                                                  : i_item.operand_a;
    assign w_in_mag_b = i_item.operand_b[OPD_W-1] ? (~i_item.operand_b + OPD_W'(1))
                                                  : i_item.operand_b;

    // restoring remainder step, next magnitude bit shifted in
    assign w_ta = {r_a, r_mag_a[OPD_W-1]};
    assign w_tb = {r_b, r_mag_b[OPD_W-1]};
    assign w_da = w_ta - w_mod_x;
    assign w_db = w_tb - w_mod_x;

    // negative operand with nonzero remainder moves up by m
    assign w_fix_a = (r_neg_a && r_a != '0) ? (w_mod - r_a) : r_a;
    assign w_fix_b = (r_neg_b && r_b != '0) ? (w_mod - r_b) : r_b;

    // single-step operations on the corrected operands
    always_comb begin
        case (r_kind)
            KIND_ADD: w_op_res = mod_add(w_fix_a, w_fix_b, w_mod);
            KIND_SUB: w_op_res = (w_fix_a < w_fix_b) ? (w_fix_a + (w_mod - w_fix_b))
                                                     : (w_fix_a - w_fix_b);
            KIND_RED: w_op_res = w_fix_a;
            default:  w_op_res = '0;
        endcase
    end

    assign i_item.ready = (r_state == S_IDLE);
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_out_free   = !r_out_valid || o_res.ready;
    assign o_res.valid  = r_out_valid;
    assign o_res.result = r_out_result;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept) n_state = S_RED;
            S_RED:  if (r_cnt == CNT_LAST) n_state = S_FIX;
            S_FIX:  n_state = (r_kind == KIND_MUL) ? S_MUL : S_DONE;
            S_MUL:  if (r_b == '0) n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mod       <= MOD_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mod <= i_cfg_data;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_kind  <= i_item.kind;
                r_neg_a <= i_item.operand_a[OPD_W-1];
                r_neg_b <= i_item.operand_b[OPD_W-1];
                r_mag_a <= w_in_mag_a;
                r_mag_b <= w_in_mag_b;
                r_a     <= '0;
                r_b     <= '0;
                r_cnt   <= '0;
            end
            S_RED: begin
                r_a     <= (w_ta >= w_mod_x) ? w_da[MOD_W-1:0] : w_ta[MOD_W-1:0];
                r_b     <= (w_tb >= w_mod_x) ? w_db[MOD_W-1:0] : w_tb[MOD_W-1:0];
                r_mag_a <= {r_mag_a[OPD_W-2:0], 1'b0};
                r_mag_b <= {r_mag_b[OPD_W-2:0], 1'b0};
                r_cnt   <= r_cnt + CNT_W'(1);
            end
            S_FIX: begin
                r_a   <= w_fix_a;
                r_b   <= w_fix_b;
                r_acc <= w_op_res;
            end
            S_MUL: begin
                // one bit of the second operand per cycle, lowest first
                if (r_b != '0) begin
                    if (r_b[0]) begin
                        r_acc <= mod_add(r_acc, r_a, w_mod);
                    end
                    r_a <= mod_add(r_a, r_a, w_mod);
                    r_b <= {1'b0, r_b[MOD_W-1:1]};
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_result <= r_acc;
                end
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    // a transfer in starts the reduction pass from bit zero
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_RED && r_cnt == '0))
        else $error("accepted item did not start reduction");

    // the reduction pass ends after the last operand bit
    a_red_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RED && r_cnt == CNT_LAST) |=> (r_state == S_FIX))
        else $error("reduction pass did not end on the last bit");

    // a result appears only out of the done state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside the done state");

endmodule

`default_nettype wire

@@ test/modular_arithmetic_unit_core_tb.sv @@
// self-checking testbench for the modular arithmetic unit core
`timescale 1ns / 1ps

module modular_arithmetic_unit_core_tb;
    import mau_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 5;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int LONG_HOLD       = 700;
    localparam int SETTLE_CYCLES   = 200;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int REPORT_MAX      = 10;

    localparam logic [OPD_W-1:0] OPD_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [OPD_W-1:0] OPD_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [OPD_W-1:0] OPD_ONES = '1;
    localparam t_res             MOD_TOP  = '1;

    // output-side ready patterns
    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_SQUARE} t_rx_mode;

    // expected residues and the checks against them
    class t_mod_scoreboard;
        t_res pending[$];
        int   checked;
        int   failures;

        // bring a signed 64-bit operand into [0, m)
        function logic [63:0] residue(logic [63:0] v, logic [63:0] m);
            logic [63:0] r;
            if (!v[63]) begin
                return v % m;
            end
            r = (64'd0 - v) % m;
            return (r == 64'd0) ? 64'd0 : m - r;
        endfunction

        function t_res predict(logic [KIND_W-1:0] kind, logic [63:0] a, logic [63:0] b,
                               t_res mod_reg);
            logic [63:0]  m;
            logic [63:0]  ra;
            logic [63:0]  rb;
            logic [63:0]  r;
            logic [64:0]  sum;
            logic [127:0] prod;
            // a zero modulus behaves as one
            m  = (mod_reg == '0) ? 64'd1 : {1'b0, mod_reg};
            ra = residue(a, m);
            rb = residue(b, m);
            case (kind)
                KIND_ADD: begin
                    sum = {1'b0, ra} + {1'b0, rb};
                    if (sum >= {1'b0, m}) begin
                        sum = sum - {1'b0, m};
                    end
                    r = sum[63:0];
                end
                KIND_SUB: begin
                    r = (ra >= rb) ? ra - rb : ra + (m - rb);
                end
                KIND_MUL: begin
                    // full-width product, then one reduction
                    prod = {64'd0, ra} * {64'd0, rb};
                    prod = prod % {64'd0, m};
                    r    = prod[63:0];
                end
                default: begin
                    r = ra;
                end
            endcase
            return r[MOD_W-1:0];
        endfunction

        function void note_item(logic [KIND_W-1:0] kind, logic [63:0] a, logic [63:0] b,
                                t_res mod_reg);
            pending.push_back(predict(kind, a, b, mod_reg));
        endfunction

        function void check_result(t_res got);
            t_res exp_v;
            if (pending.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX) begin
                    $display("error: result %h with no transfer outstanding", got);
                end
                return;
            end
            exp_v = pending.pop_front();
            checked++;
            if (got !== exp_v) begin
                failures++;
                if (failures <= REPORT_MAX) begin
                    $display("error: result mismatch, expected %h actual %h", exp_v, got);
                end
            end
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     i_cfg_we;
    t_res     i_cfg_data;

    mau_in_if  item_if ();
    mau_out_if res_if ();

    t_mod_scoreboard sb = new();

    t_res     cur_modulus = 63'd1;
    int       cycles = 0;
    int       settings_used = 0;
    int       items_sent = 0;
    int       kind_seen[4];
    int       hold_req = 0;
    int       hold_ack = 0;
    int       hold_left = 0;
    int       holds_done = 0;
    t_rx_mode rx_mode = RX_ALWAYS;
    logic [31:0] rx_tick = '0;

    modular_arithmetic_unit_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_if),
        .o_res      (res_if)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #HALF_PERIOD;
        i_clk = 1'b1;
        #HALF_PERIOD;
    end

    // run guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     sb.pending.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random ready patterns plus requested long holds
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 32'd1;
        if (hold_req != hold_ack) begin
            hold_ack      <= hold_req;
            hold_left     <= LONG_HOLD;
            holds_done    <= holds_done + 1;
            res_if.ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            if (rx_tick[7:0] == 8'd0) begin
                rx_mode <= t_rx_mode'($urandom_range(0, 3));
            end
            case (rx_mode)
                RX_ALWAYS: res_if.ready <= 1'b1;
                RX_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: res_if.ready <= ($urandom_range(0, 4) == 0);
                default:   res_if.ready <= rx_tick[4];
            endcase
        end
    end

    // result transfers
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            sb.check_result(res_if.result);
        end
    end

    // operand mix: random, residues, edges, small, near and at multiples of m
    function automatic logic [63:0] rand_operand(logic [63:0] m);
        logic [63:0] v;
        int          sel;
        sel = $urandom_range(0, 7);
        case (sel)
            3: v = {$urandom, $urandom} % m;
            4: begin
                case ($urandom_range(0, 4))
                    0:       v = 64'd0;
                    1:       v = 64'd1;
                    2:       v = OPD_ONES;
                    3:       v = OPD_MIN;
                    default: v = OPD_MAX;
                endcase
            end
            5: v = m + 64'($urandom_range(0, 2)) - 64'd1;
            6: v = 64'($urandom_range(0, 300));
            7: v = m * 64'($urandom_range(0, 5));
            default: v = {$urandom, $urandom};
        endcase
        if (sel >= 3 && $urandom_range(0, 1) == 1) begin
            v = 64'd0 - v;
        end
        return v;
    endfunction

    // offer one item and hold it until the transfer
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [63:0] a,
                             input logic [63:0] b);
        item_if.valid     <= 1'b1;
        item_if.kind      <= kind;
        item_if.operand_a <= a;
        item_if.operand_b <= b;
        do begin
            @(posedge i_clk);
        end while (!item_if.ready);
        sb.note_item(kind, a, b, cur_modulus);
        items_sent++;
        kind_seen[kind]++;
    endtask

    task automatic idle_cycles(input int n);
        item_if.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic idle_drain();
        item_if.valid <= 1'b0;
        while (sb.pending.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_modulus(input t_res v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_modulus = v;
        settings_used++;
    endtask

    task automatic run_random(input int n, input bit steady, input int hold_at,
                              input int drain_at);
        int                burst_left;
        int                k;
        logic [KIND_W-1:0] kind;
        logic [63:0]       m;
        m = (cur_modulus == '0) ? 64'd1 : {1'b0, cur_modulus};
        burst_left = $urandom_range(1, 24);
        for (k = 0; k < n; k++) begin
            // long output hold while items keep coming
            if (k == hold_at) begin
                hold_req <= hold_req + 1;
            end
            if (k == drain_at) begin
                idle_drain();
            end
            kind = KIND_W'($urandom_range(KIND_ADD, KIND_RED));
            send_item(kind, rand_operand(m), rand_operand(m));
            if (!steady) begin
                burst_left--;
                if (burst_left == 0) begin
                    idle_cycles(($urandom_range(0, 9) == 0) ? $urandom_range(20, 150)
                                                              : $urandom_range(1, 12));
                    burst_left = $urandom_range(1, 24);
                end
            end
        end
        idle_drain();
    endtask

    // main sequence
    initial begin
        int   p;
        t_res m;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_data        = '0;
        item_if.valid     = 1'b0;
        item_if.kind      = KIND_ADD;
        item_if.operand_a = '0;
        item_if.operand_b = '0;
        res_if.ready      = 1'b0;
        for (p = 0; p < 4; p++) begin
            kind_seen[p] = 0;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // modulus left at its reset value
        run_random(8, 1'b0, -1, -1);

        // directed corners at the largest modulus
        write_modulus(MOD_TOP);
        send_item(KIND_ADD, OPD_MAX, OPD_MAX);
        send_item(KIND_ADD, OPD_MIN, OPD_ONES);
        send_item(KIND_ADD, 64'd1, OPD_ONES);
        send_item(KIND_SUB, 64'd0, 64'd1);
        send_item(KIND_SUB, OPD_MIN, OPD_MAX);
        send_item(KIND_SUB, OPD_MAX - 64'd1, OPD_MIN);
        send_item(KIND_MUL, OPD_ONES, OPD_ONES);
        send_item(KIND_MUL, OPD_MAX - 64'd1, 64'd0);
        send_item(KIND_MUL, 64'd12345, OPD_MAX);
        send_item(KIND_MUL, OPD_MIN, OPD_MIN);
        send_item(KIND_MUL, OPD_MAX - 64'd1, OPD_MAX - 64'd1);
        send_item(KIND_RED, OPD_MIN, 64'd0);
        send_item(KIND_RED, OPD_ONES, OPD_MIN);
        send_item(KIND_RED, OPD_MAX, OPD_ONES);
        send_item(KIND_RED, 64'd0, OPD_MAX);
        idle_drain();

        // random phases over a spread of moduli, zero and the top value included
        for (p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       m = '0;
                1:       m = 63'd2;
                2:       m = 63'd3;
                3:       m = 63'd7;
                4:       m = 63'd1_000_003;
                5:       m = 63'hFFFF_FFFF;
                6:       m = 63'h4000_0000_0000_0000;
                7:       m = MOD_TOP - 63'd1;
                8:       m = t_res'({$urandom, $urandom}) | 63'h4000_0000_0000_0000;
                9:       m = t_res'($urandom_range(1, 32'h7FFF_FFFF));
                10:      m = MOD_TOP;
                default: m = 63'd1;
            endcase
            write_modulus(m);
            run_random(ITEMS_PER_PHASE, p == 3 || p == 8, (p == 8) ? 30 : -1,
                       (p == 5) ? 45 : -1);
        end

        idle_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d items (add %0d, sub %0d, mul %0d, reduce %0d), %0d moduli",
                 items_sent, kind_seen[KIND_ADD], kind_seen[KIND_SUB], kind_seen[KIND_MUL],
                 kind_seen[KIND_RED], settings_used);
        $display("%0d results checked, %0d failures, %0d long output holds, %0d cycles",
                 sb.checked, sb.failures, holds_done, cycles);
        if (sb.failures == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
